[rtl/huffman_stream_decoder_macros.svh]
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef HUFFMAN_STREAM_DECODER_MACROS_SVH
`define HUFFMAN_STREAM_DECODER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define HSD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsd: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define HSD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsd: next-cycle check failed");
`else
`define HSD_ASSERT_IMP(label, ante, cons)
`define HSD_ASSERT_NXT(label, ante, cons)
`endif
`endif

[rtl/hsd_pkg.sv]
package hsd_pkg;

	// Default sizes.
	localparam int NODES_DEFAULT = 512;
	localparam int QUEUE_DEPTH   = 4;

	// Byte handling.
	localparam int             BYTE_BITS     = 8;
	localparam logic [7:0]     ESCAPE_OFFSET = 8'd40;

	// Command codes on the input channel.
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// Input transaction.
	typedef struct packed {
		logic       command;
		logic [8:0] node_index;
		logic [8:0] left_child;
		logic [8:0] right_child;
		logic       is_leaf;
		logic [7:0] leaf_symbol;
		logic [7:0] data_byte;
		logic       escaped;
		logic [3:0] valid_bits;
	} in_item_t;

	// Output transaction.
	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} result_t;

	// One stored tree node.
	typedef struct packed {
		logic [8:0] left_child;
		logic [8:0] right_child;
		logic       is_leaf;
		logic [7:0] leaf_symbol;
	} node_t;

	localparam int NODE_BITS = $bits(node_t);

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	// Classified work item passed from the front to the back.
	typedef struct packed {
		op_t        op;
		logic [8:0] node_index;
		node_t      node;
		logic [7:0] data_byte;
		logic [3:0] bit_count;
	} q_item_t;

endpackage

[rtl/hsd_front.sv]
module hsd_front #(
	parameter int NODES = hsd_pkg::NODES_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  hsd_pkg::in_item_t item,
	output logic             push,
	output hsd_pkg::q_item_t push_item,
	input  logic             full
);
	import hsd_pkg::*;

	logic    valid_s1;
	q_item_t item_s1;
	q_item_t cls;
	logic    keep;

	// Classify the incoming transaction: undo the escape, clamp the bit count
	// and drop loads that address a node beyond the tree.
	always_comb begin
		cls.op               = (item.command == CMD_DECODE) ? OP_DECODE : OP_LOAD;
		cls.node_index       = item.node_index;
		cls.node.left_child  = item.left_child;
		cls.node.right_child = item.right_child;
		cls.node.is_leaf     = item.is_leaf;
		cls.node.leaf_symbol = item.leaf_symbol;
		cls.data_byte        = item.escaped ? (item.data_byte - ESCAPE_OFFSET) : item.data_byte;
		cls.bit_count        = (item.valid_bits > 4'(BYTE_BITS)) ? 4'(BYTE_BITS) : item.valid_bits;
		keep                 = !((item.command == CMD_LOAD) && (32'(item.node_index) >= NODES));
	end

	// One register stage in front of the queue.
	assign item_stall = valid_s1 && full;
	assign push       = valid_s1 && !full;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= cls;
		end
	end

endmodule

[rtl/hsd_queue.sv]
`include "huffman_stream_decoder_macros.svh"

module hsd_queue #(
	parameter int DEPTH = hsd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hsd_pkg::q_item_t push_item,
	output logic             full,
	input  logic             pop,
	output hsd_pkg::q_item_t head,
	output logic             empty
);
	import hsd_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	q_item_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	`HSD_ASSERT_IMP(a_no_overflow, push, !full)
	`HSD_ASSERT_IMP(a_no_underflow, pop, !empty)

endmodule

[rtl/hsd_ram.sv]
module hsd_ram #(
	parameter int WIDTH = hsd_pkg::NODE_BITS,
	parameter int DEPTH = hsd_pkg::NODES_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/hsd_back.sv]
`include "huffman_stream_decoder_macros.svh"

module hsd_back #(
	parameter int NODES = hsd_pkg::NODES_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hsd_pkg::q_item_t head,
	input  logic             empty,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output hsd_pkg::result_t result
);
	import hsd_pkg::*;

	localparam int AW = $clog2(NODES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	// Where the current node's children come from.
	typedef enum logic [1:0] {
		SRC_ROOT,
		SRC_START,
		SRC_STEP
	} src_t;

	state_t         state_q;
	src_t           src_q;
	logic [8:0]     cur_idx_q;
	logic [8:0]     walk_pos_q;
	logic [7:0]     shift_q;
	logic [3:0]     cnt_q;
	logic           pend_valid_q;
	logic [7:0]     pend_sym_q;
	logic           out_valid_q;
	result_t        out_q;
	node_t          root_q;

	logic [NODE_BITS-1:0] rdata;
	node_t          rd_node;
	node_t          cur_node;
	logic [8:0]     cur_index;
	logic [8:0]     next_idx;
	logic           next_ok;
	logic           reached_leaf;
	logic           out_free;
	logic           walk_hold;
	logic           flush_hold;
	logic           load_pop;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic           out_push;
	result_t        out_data;

	assign rd_node  = node_t'(rdata);
	assign load_pop = pop && (head.op == OP_LOAD);
	assign pop      = (state_q == ST_IDLE) && !empty;

	// One tree step: test the node just fetched, pick the current node and
	// follow the child chosen by the next code bit.
	always_comb begin
		reached_leaf = (state_q == ST_WALK) && (src_q == SRC_STEP) && rd_node.is_leaf;
		if ((src_q == SRC_ROOT) || reached_leaf) begin
			cur_node  = root_q;
			cur_index = '0;
		end else begin
			cur_node  = rd_node;
			cur_index = cur_idx_q;
		end
		next_idx = shift_q[BYTE_BITS-1] ? cur_node.right_child : cur_node.left_child;
		next_ok  = (32'(next_idx) < NODES);
	end

	// Output register handshake and hold conditions.
	assign out_free   = !out_valid_q || !result_stall;
	assign walk_hold  = reached_leaf && pend_valid_q && !out_free;
	assign flush_hold = pend_valid_q && !out_free;

	// A symbol waits in the pending register until it is known whether it is
	// the last one of its byte.
	always_comb begin
		out_push = 1'b0;
		out_data = '{symbol: pend_sym_q, last: 1'b0};
		if ((state_q == ST_WALK) && !walk_hold && reached_leaf && pend_valid_q) begin
			out_push = 1'b1;
		end else if ((state_q == ST_FLUSH) && pend_valid_q && out_free) begin
			out_push      = 1'b1;
			out_data.last = 1'b1;
		end
	end

	// Tree memory read control.
	always_comb begin
		ram_re    = (pop && (head.op == OP_DECODE)) ||
		            ((state_q == ST_WALK) && !walk_hold && (cnt_q != '0) && next_ok);
		ram_raddr = (state_q == ST_IDLE) ? walk_pos_q[AW-1:0] : next_idx[AW-1:0];
	end

	hsd_ram #(
		.WIDTH(NODE_BITS),
		.DEPTH(NODES)
	) u_tree (
		.clk  (clk),
		.we   (load_pop),
		.waddr(head.node_index[AW-1:0]),
		.wdata(head.node),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	// Copy of the root node, so that a return to the root costs no read.
	always_ff @(posedge clk) begin
		if (load_pop && (head.node_index == '0)) begin
			root_q <= head.node;
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			src_q        <= SRC_ROOT;
			cur_idx_q    <= '0;
			walk_pos_q   <= '0;
			shift_q      <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_sym_q   <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= out_push;
			end
			if (out_push) begin
				out_q <= out_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && (head.op == OP_DECODE)) begin
						state_q   <= ST_WALK;
						src_q     <= SRC_START;
						cur_idx_q <= walk_pos_q;
						shift_q   <= head.data_byte;
						cnt_q     <= head.bit_count;
					end
				end
				ST_WALK: begin
					if (!walk_hold) begin
						if (reached_leaf) begin
							pend_valid_q <= 1'b1;
							pend_sym_q   <= rd_node.leaf_symbol;
						end
						if (cnt_q != '0) begin
							shift_q <= shift_q << 1;
							cnt_q   <= cnt_q - 1'b1;
							if (next_ok) begin
								src_q     <= SRC_STEP;
								cur_idx_q <= next_idx;
							end else begin
								src_q <= SRC_ROOT;
							end
						end else begin
							walk_pos_q <= cur_index;
							state_q    <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!flush_hold) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`HSD_ASSERT_IMP(a_idle_no_pending, state_q == ST_IDLE, !pend_valid_q)
	`HSD_ASSERT_IMP(a_walk_not_last, out_push && (state_q == ST_WALK), !out_data.last)
	`HSD_ASSERT_NXT(a_decode_walks, pop && (head.op == OP_DECODE), state_q == ST_WALK)

endmodule

[rtl/huffman_stream_decoder.sv]
// Huffman stream decoder. A load transaction writes one node of the code tree
// (node 0 is the root); a decode transaction carries one packed byte whose
// leading bits walk the tree from where the previous byte left off, and every
// leaf reached yields one result transaction, the last of a byte flagged by
// last. A register stage and a four-entry queue in front of the tree walker let
// new transactions be taken while the walker is busy or its output is stalled.
// In the walker a load is written to the tree memory as it is popped, and a
// byte is decoded in steps: a fetch of the node at the saved walk position, a
// step per code bit through the single read port of the tree memory, a step to
// close the walk and one to hand over the last symbol. A stall on the output
// holds the walk when a second symbol of the byte is ready, and holds the
// hand-over of the last symbol until the output register is free. Tree entries
// are not cleared at reset; a node must be loaded before the walk reaches it.
module huffman_stream_decoder #(
	parameter int NODES       = hsd_pkg::NODES_DEFAULT,
	parameter int QUEUE_DEPTH = hsd_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  hsd_pkg::in_item_t item,
	output logic              result_valid,
	input  logic              result_stall,
	output hsd_pkg::result_t  result
);
	import hsd_pkg::*;

	logic    push;
	q_item_t push_item;
	logic    full;
	logic    pop;
	q_item_t head;
	logic    empty;

	// Front: accepts and classifies transactions.
	hsd_front #(
		.NODES(NODES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	// Queue between front and walker.
	hsd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	// Back: tree storage and walker.
	hsd_back #(
		.NODES(NODES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

[bench/tb_huffman_stream_decoder.sv]
module tb_huffman_stream_decoder;
	import hsd_pkg::*;

	localparam int NODES        = NODES_DEFAULT;
	localparam int ITEM_TARGET  = 320;
	localparam int STUCK_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 40;
	localparam int IN_BITS      = $bits(in_item_t);

	// Idle percentages per phase: none, sender gaps, receiver stalls, both.
	localparam int GAP_PCT[4]   = '{0, 52, 0, 33};
	localparam int STALL_PCT[4] = '{0, 0, 52, 33};

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     item_valid   = 1'b0;
	logic     item_stall;
	in_item_t item         = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	result_t  result;

	// Stimulus waiting to be driven and symbols waiting to come out.
	in_item_t   items_pending[$];
	result_t    symbols_due[$];

	// Private copy of the code tree and walk position, updated per accepted transaction.
	node_t      tree_copy[0:NODES-1];
	logic [8:0] walk_pos = '0;

	// Nodes that have been queued for loading; the stray overwrites only link to these.
	bit         closed[0:NODES-1];
	logic [8:0] closed_list[$];

	logic [1:0] idle_phase   = '0;
	int         issued       = 0;
	int         stuck_cycles = 0;
	int         mismatches   = 0;
	logic       next_valid;
	in_item_t   next_item;
	result_t    want;

	huffman_stream_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #4 clk = ~clk;

	// Apply one accepted transaction to the tree copy and queue the symbols it yields.
	task automatic walk_and_emit(input in_item_t it);
		logic [7:0]  code;
		int unsigned steps;
		logic [8:0]  pos;
		logic [8:0]  hop;
		result_t     batch[$];
		if (it.command == CMD_LOAD) begin
			tree_copy[it.node_index] = '{it.left_child, it.right_child, it.is_leaf,
				it.leaf_symbol};
			return;
		end
		code  = it.escaped ? it.data_byte - ESCAPE_OFFSET : it.data_byte;
		steps = (it.valid_bits > 4'd8) ? 32'd8 : 32'(it.valid_bits);
		pos   = walk_pos;
		for (int b = 0; b < steps; b++) begin
			hop = code[7 - b] ? tree_copy[pos].right_child : tree_copy[pos].left_child;
			if (tree_copy[hop].is_leaf) begin
				batch.push_back('{tree_copy[hop].leaf_symbol, 1'b0});
				pos = '0;
			end else begin
				pos = hop;
			end
		end
		walk_pos = pos;
		if (batch.size() != 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			symbols_due.push_back(batch[i]);
	endtask

	// Load transaction; the decode fields carry random filler.
	task automatic queue_load(input logic [8:0] idx, input logic [8:0] lft,
		input logic [8:0] rgt, input logic leaf, input logic [7:0] sym);
		in_item_t it;
		it             = IN_BITS'({$urandom(), $urandom()});
		it.command     = CMD_LOAD;
		it.node_index  = idx;
		it.left_child  = lft;
		it.right_child = rgt;
		it.is_leaf     = leaf;
		it.leaf_symbol = sym;
		items_pending.push_back(it);
		if (!closed[idx]) begin
			closed[idx] = 1'b1;
			closed_list.push_back(idx);
		end
	endtask

	// Decode transaction; the load fields carry random filler.
	task automatic queue_decode(input logic [7:0] data, input logic esc, input logic [3:0] nbits);
		in_item_t it;
		it            = IN_BITS'({$urandom(), $urandom()});
		it.command    = CMD_DECODE;
		it.data_byte  = data;
		it.escaped    = esc;
		it.valid_bits = nbits;
		items_pending.push_back(it);
	endtask

	// Grow a random full binary tree from the root and queue its nodes in random order.
	task automatic plan_tree(input int leaves);
		logic [8:0] open_ends[$];
		logic [8:0] members[$];
		node_t      shape[int];
		bit         taken[0:NODES-1];
		logic [8:0] parent;
		logic [8:0] kid_l;
		logic [8:0] kid_r;
		int         k;
		open_ends.push_back(9'd0);
		members.push_back(9'd0);
		taken[0] = 1'b1;
		repeat (leaves - 1) begin
			k      = $urandom_range(open_ends.size() - 1);
			parent = open_ends[k];
			open_ends.delete(k);
			do kid_l = 9'($urandom_range(NODES - 1, 1)); while (taken[kid_l]);
			taken[kid_l] = 1'b1;
			do kid_r = 9'($urandom_range(NODES - 1, 1)); while (taken[kid_r]);
			taken[kid_r] = 1'b1;
			shape[parent] = '{kid_l, kid_r, 1'b0, 8'($urandom())};
			open_ends.push_back(kid_l);
			open_ends.push_back(kid_r);
			members.push_back(kid_l);
			members.push_back(kid_r);
		end
		// Leaf children are only read if a leaf becomes a walk start; keep them inside the tree.
		foreach (open_ends[i])
			shape[open_ends[i]] = '{members[$urandom_range(members.size() - 1)],
				members[$urandom_range(members.size() - 1)], 1'b1, 8'($urandom())};
		while (members.size() != 0) begin
			k = $urandom_range(members.size() - 1);
			queue_load(members[k], shape[members[k]].left_child, shape[members[k]].right_child,
				shape[members[k]].is_leaf, shape[members[k]].leaf_symbol);
			members.delete(k);
		end
	endtask

	// Input driver: holds a transaction until it is taken, then perhaps idles.
	always @(posedge clk) begin
		if (arst_n) begin
			next_valid = item_valid;
			next_item  = item;
			if (item_valid && !item_stall) begin
				walk_and_emit(item);
				next_valid = 1'b0;
			end
			if (!next_valid && items_pending.size() != 0 &&
				$urandom_range(99) >= GAP_PCT[idle_phase]) begin
				next_item  = items_pending.pop_front();
				next_valid = 1'b1;
				issued++;
			end
			item_valid <= next_valid;
			item       <= next_item;
			idle_phase <= 2'((issued / PHASE_ITEMS) % 4);
		end
	end

	// Output monitor: checks each symbol against the oldest expectation and drives stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (symbols_due.size() == 0) begin
					$error("symbol: expected none, got 0x%02h (last %0b)", result.symbol,
						result.last);
					mismatches++;
				end else begin
					want = symbols_due.pop_front();
					if (result.symbol !== want.symbol) begin
						$error("symbol: expected 0x%02h, got 0x%02h", want.symbol,
							result.symbol);
						mismatches++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, result.last);
						mismatches++;
					end
				end
			end
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			result_stall <= ($urandom_range(99) < STALL_PCT[idle_phase]);
		end
	end

	// Stimulus plan, reset and end of run.
	initial begin
		int         leaves;
		logic [3:0] nbits;
		// Small tree touching the extreme node indices and symbols.
		queue_load(9'd0, 9'd1, 9'd511, 1'b0, 8'h00);
		queue_load(9'd1, 9'd0, 9'd0, 1'b1, 8'h00);
		queue_load(9'd511, 9'd2, 9'd256, 1'b0, 8'hFF);
		queue_load(9'd2, 9'd0, 9'd0, 1'b1, 8'hFF);
		queue_load(9'd256, 9'd511, 9'd511, 1'b1, 8'hA5);
		// Eight symbols from one byte, then all-ones, then a short byte.
		queue_decode(8'h00, 1'b0, 4'd8);
		queue_decode(8'hFF, 1'b0, 4'd8);
		queue_decode(8'hB6, 1'b0, 4'd7);
		// Escaped bytes, the second wrapping below zero.
		queue_decode(8'hE8, 1'b1, 4'd8);
		queue_decode(8'h10, 1'b1, 4'd8);
		// A code split across two bytes.
		queue_decode(8'h80, 1'b0, 4'd1);
		queue_decode(8'h40, 1'b0, 4'd2);
		// No code bits at all, and counts above eight.
		queue_decode(8'h5A, 1'b0, 4'd0);
		queue_decode(8'h3C, 1'b0, 4'd15);
		queue_decode(8'hC3, 1'b1, 4'd9);
		// A root flagged as a leaf is still walked through its children.
		queue_load(9'd0, 9'd1, 9'd2, 1'b1, 8'h77);
		queue_decode(8'h00, 1'b0, 4'd3);
		queue_decode(8'h80, 1'b0, 4'd1);
		queue_decode(8'h4F, 1'b1, 4'd8);
		queue_load(9'd0, 9'd1, 9'd511, 1'b0, 8'h00);

		// Random trees, each followed by a stream of bytes with the odd stray overwrite.
		while (items_pending.size() < ITEM_TARGET) begin
			leaves = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 2);
			plan_tree(leaves);
			repeat ($urandom_range(30, 8)) begin
				if ($urandom_range(19) == 0)
					queue_load(closed_list[$urandom_range(closed_list.size() - 1)],
						closed_list[$urandom_range(closed_list.size() - 1)],
						closed_list[$urandom_range(closed_list.size() - 1)],
						1'($urandom()), 8'($urandom()));
				case ($urandom_range(19))
					0:       nbits = 4'd0;
					1:       nbits = 4'($urandom_range(15, 9));
					2, 3, 4: nbits = 4'($urandom_range(7, 1));
					default: nbits = 4'd8;
				endcase
				queue_decode(8'($urandom()), $urandom_range(9) < 3, nbits);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while ((items_pending.size() != 0 || item_valid || symbols_due.size() != 0) &&
			stuck_cycles < STUCK_LIMIT)
			@(negedge clk);

		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			@(negedge clk);
			if (symbols_due.size() != 0)
				$error("%0d expected symbols never arrived", symbols_due.size());
			if (mismatches == 0 && symbols_due.size() == 0)
				$display("SCOREBOARD CLEAN");
			else
				$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
